>>> design/ddo_pkg.sv
// Shared types, constants and helper functions for the differential drive odometry block.
// No dependencies.
package ddo_pkg;

  localparam int OPA_W     = 52;
  localparam int OPB_W     = 32;
  localparam int RES_W     = 84;
  localparam int DVS_W     = 23;
  localparam int MUL_STEPS = 32;
  localparam int DIV_STEPS = 52;
  localparam int CNT_W     = 6;

  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 24;
  localparam int THR_W      = 15;
  localparam int MPP_W      = 24;
  localparam int PER_W      = 10;
  localparam int BASE_W     = 12;
  localparam int COUNT_W    = 16;
  localparam int SPEED_W    = 32;
  localparam int POS_OUT_W  = 48;
  localparam int ANGLE_W    = 32;
  localparam int QUAT_W     = 32;
  localparam int CORD_W     = 34;

  localparam logic [THR_W-1:0]  THR_RESET    = 15'd520;
  localparam logic [MPP_W-1:0]  MPP_RESET    = 24'd9503;
  localparam logic [PER_W-1:0]  PER_RESET    = 10'd10;
  localparam logic [BASE_W-1:0] BASE_RESET   = 12'd124;
  localparam logic [OPB_W-1:0]  TWO_PI_INV   = 32'd683565276;
  localparam logic [OPB_W-1:0]  ANG_SCALE    = 32'd1000;
  localparam logic signed [CORD_W-1:0] CORDIC_GAIN = 34'sd652032874;
  localparam logic [ANGLE_W-1:0] QUARTER_TURN = 32'h4000_0000;
  localparam logic [ANGLE_W-1:0] HALF_TURN    = 32'h8000_0000;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_THR    = 2'd0,
    REG_MPP    = 2'd1,
    REG_PERIOD = 2'd2,
    REG_BASE   = 2'd3
  } cfg_reg_t;

  typedef enum logic {
    OP_MUL,
    OP_DIV
  } md_op_t;

  typedef struct packed {
    logic   start;
    md_op_t op;
  } md_req_t;

  typedef enum logic [4:0] {
    S_IDLE,
    S_DL,
    S_DR,
    S_SUMS,
    S_LIN,
    S_AMUL,
    S_ADIV,
    S_QDIV,
    S_QMUL,
    S_RMUL,
    S_RDIV,
    S_COS1,
    S_PX,
    S_PY,
    S_COS2,
    S_OUT
  } state_t;

  function automatic logic signed [31:0] sat32(input logic signed [63:0] v);
    logic signed [31:0] r;
    if (v > 64'sd2147483647) begin
      r = 32'sh7FFF_FFFF;
    end else if (v < -64'sd2147483648) begin
      r = 32'sh8000_0000;
    end else begin
      r = v[31:0];
    end
    return r;
  endfunction

  function automatic logic signed [31:0] sat_signed(input logic [OPA_W-1:0] mag,
                                                    input logic neg);
    logic signed [63:0] v;
    v = signed'(64'(mag));
    if (neg) begin
      v = -v;
    end
    return sat32(v);
  endfunction

  function automatic logic [31:0] atan_unit(input logic [4:0] i);
    logic [31:0] r;
    case (i)
      5'd0:  r = 32'd536870912;
      5'd1:  r = 32'd316933406;
      5'd2:  r = 32'd167458907;
      5'd3:  r = 32'd85004756;
      5'd4:  r = 32'd42667331;
      5'd5:  r = 32'd21354465;
      5'd6:  r = 32'd10679838;
      5'd7:  r = 32'd5340245;
      5'd8:  r = 32'd2670163;
      5'd9:  r = 32'd1335087;
      5'd10: r = 32'd667544;
      5'd11: r = 32'd333772;
      5'd12: r = 32'd166886;
      5'd13: r = 32'd83443;
      5'd14: r = 32'd41722;
      5'd15: r = 32'd20861;
      5'd16: r = 32'd10430;
      5'd17: r = 32'd5215;
      5'd18: r = 32'd2608;
      5'd19: r = 32'd1304;
      5'd20: r = 32'd652;
      5'd21: r = 32'd326;
      5'd22: r = 32'd163;
      5'd23: r = 32'd81;
      5'd24: r = 32'd41;
      5'd25: r = 32'd20;
      5'd26: r = 32'd10;
      5'd27: r = 32'd5;
      5'd28: r = 32'd3;
      5'd29: r = 32'd1;
      5'd30: r = 32'd1;
      default: r = 32'd0;
    endcase
    return r;
  endfunction

endpackage

>>> design/ddo_if.sv
// Valid/ready channel interfaces: wheel count requests, pose results, register writes.
// Depends on ddo_pkg.
interface ddo_in_if import ddo_pkg::*;;
  logic                       valid;
  logic                       ready;
  logic signed [COUNT_W-1:0]  left_count;
  logic signed [COUNT_W-1:0]  right_count;
  modport source (output valid, left_count, right_count, input ready);
  modport sink (input valid, left_count, right_count, output ready);
endinterface

interface ddo_out_if import ddo_pkg::*;;
  logic                        valid;
  logic                        ready;
  logic                        rejected;
  logic signed [SPEED_W-1:0]   linear_speed;
  logic signed [SPEED_W-1:0]   angular_speed;
  logic signed [POS_OUT_W-1:0] position_x;
  logic signed [POS_OUT_W-1:0] position_y;
  logic [ANGLE_W-1:0]          heading;
  logic signed [QUAT_W-1:0]    quat_w;
  logic signed [QUAT_W-1:0]    quat_z;
  modport source (output valid, rejected, linear_speed, angular_speed, position_x,
                  position_y, heading, quat_w, quat_z, input ready);
  modport sink (input valid, rejected, linear_speed, angular_speed, position_x,
                position_y, heading, quat_w, quat_z, output ready);
endinterface

interface ddo_cfg_if import ddo_pkg::*;;
  logic                  valid;
  logic                  ready;
  logic [CFG_IDX_W-1:0]  index;
  logic [CFG_DATA_W-1:0] data;
  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

>>> design/ddo_muldiv.sv
// Bit-serial unsigned multiplier and restoring divider sharing one step counter and result port.
// Depends on ddo_pkg.
module ddo_muldiv import ddo_pkg::*; (
  input  logic             clk,
  input  logic             rst,
  input  md_req_t          req,
  input  logic [OPA_W-1:0] a,
  input  logic [OPB_W-1:0] b,
  output logic             done,
  output logic [RES_W-1:0] res,
  output logic [DVS_W-1:0] rem
);

  logic             busy;
  md_op_t           op;
  logic [CNT_W-1:0] cnt;
  logic [RES_W-1:0] acc;
  logic [RES_W-1:0] ash;
  logic [OPB_W-1:0] bsh;
  logic [OPA_W-1:0] quo;
  logic [DVS_W:0]   remr;
  logic [DVS_W-1:0] dvs;
  logic [DVS_W:0]   rs;
  logic [CNT_W-1:0] last;

  assign rs   = {remr[DVS_W-1:0], quo[OPA_W-1]};
  assign last = (op == OP_MUL) ? CNT_W'(MUL_STEPS - 1) : CNT_W'(DIV_STEPS - 1);
  assign res  = (op == OP_MUL) ? acc : RES_W'(quo);
  assign rem  = remr[DVS_W-1:0];

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      op   <= OP_MUL;
    end else begin
      done <= 1'b0;
      if (req.start) begin
        busy <= 1'b1;
        op   <= req.op;
        cnt  <= '0;
        acc  <= '0;
        ash  <= RES_W'(a);
        bsh  <= b;
        quo  <= a;
        remr <= '0;
        dvs  <= b[DVS_W-1:0];
      end else if (busy) begin
        if (op == OP_MUL) begin
          if (bsh[0]) begin
            acc <= acc + ash;
          end
          ash <= {ash[RES_W-2:0], 1'b0};
          bsh <= {1'b0, bsh[OPB_W-1:1]};
        end else begin
          if (rs >= {1'b0, dvs}) begin
            remr <= rs - {1'b0, dvs};
            quo  <= {quo[OPA_W-2:0], 1'b1};
          end else begin
            remr <= rs;
            quo  <= {quo[OPA_W-2:0], 1'b0};
          end
        end
        cnt <= cnt + 1'b1;
        if (cnt == last) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

endmodule

>>> design/ddo_cordic.sv
// Iterative rotation-mode CORDIC on a 32-bit binary angle, one micro-rotation per cycle.
// Depends on ddo_pkg.
module ddo_cordic import ddo_pkg::*; #(
  parameter int STEPS = 24
) (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     start,
  input  logic [ANGLE_W-1:0]       angle,
  output logic                     done,
  output logic signed [QUAT_W-1:0] cos_o,
  output logic signed [QUAT_W-1:0] sin_o
);

  localparam int CW = $clog2(STEPS);

  logic                     busy;
  logic                     flip;
  logic [CW-1:0]            i;
  logic signed [CORD_W-1:0] x;
  logic signed [CORD_W-1:0] y;
  logic signed [CORD_W-1:0] z;
  logic signed [CORD_W-1:0] dx;
  logic signed [CORD_W-1:0] dy;
  logic signed [CORD_W-1:0] at;
  logic                     flip_in;
  logic [ANGLE_W-1:0]       ang_in;

  assign flip_in = angle[ANGLE_W-1] ^ angle[ANGLE_W-2];
  assign ang_in  = flip_in ? angle - HALF_TURN : angle;
  assign dx      = y >>> i;
  assign dy      = x >>> i;
  assign at      = signed'(CORD_W'(atan_unit(5'(i))));

  always_comb begin
    cos_o = sat32(64'(flip ? -x : x));
    sin_o = sat32(64'(flip ? -y : y));
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        flip <= flip_in;
        i    <= '0;
        x    <= CORDIC_GAIN;
        y    <= '0;
        z    <= CORD_W'(signed'(ang_in));
      end else if (busy) begin
        if (!z[CORD_W-1]) begin
          x <= x - dx;
          y <= y + dy;
          z <= z - at;
        end else begin
          x <= x + dx;
          y <= y - dy;
          z <= z + at;
        end
        i <= i + 1'b1;
        if (i == CW'(STEPS - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

endmodule

>>> design/differential_drive_odometry.sv
// Top level of the wheel odometry block: registers, sequencer and pose state.
// Depends on ddo_pkg, ddo_if, ddo_muldiv and ddo_cordic.
//
//   channel  dir  payload
//   sample   in   left_count, right_count
//   pose     out  rejected, speeds, position_x/y, heading, quat_w/z
//   cfg      in   index, data (register write, always ready)
//
// A rejected request goes straight to the output; an accepted one runs in turn through
// the bit-serial multiply/divide unit (seven multiplies and four divides) and two
// CORDIC passes, all used one after another.
// Synchronous reset clears pose state and restores register defaults.
// The pose register frees the input side; a held result stalls only the next completion.
module differential_drive_odometry import ddo_pkg::*; #(
  parameter int CORDIC_STEPS   = 24,
  parameter int POSITION_WIDTH = 48
) (
  input logic    clk,
  input logic    rst,
  ddo_in_if.sink sample,
  ddo_out_if.source pose,
  ddo_cfg_if.sink cfg
);

  state_t state, state_next;
  logic   go;

  logic [THR_W-1:0]  thr;
  logic [MPP_W-1:0]  mpp;
  logic [PER_W-1:0]  per;
  logic [BASE_W-1:0] base;

  logic [PER_W-1:0]    pe;
  logic [BASE_W-1:0]   we;
  logic [DVS_W-1:0]    pw;
  logic [COUNT_W:0]    lmag_in;
  logic [COUNT_W:0]    rmag_in;
  logic                rej_in;

  logic signed [COUNT_W-1:0] cl;
  logic signed [COUNT_W-1:0] cr;
  logic [COUNT_W-1:0]        cl_mag;
  logic [COUNT_W-1:0]        cr_mag;
  logic signed [40:0]        dl;
  logic signed [40:0]        dr;
  logic signed [41:0]        sum;
  logic signed [41:0]        diff;
  logic [41:0]               sum_mag;
  logic [41:0]               diff_mag;
  logic signed [41:0]        d_s;
  logic [41:0]               d_mag;
  logic [OPA_W-1:0]          tmp;
  logic [BASE_W-1:0]         rreg;
  logic [47:0]               qc;
  logic [47:0]               acc48;
  logic [ANGLE_W-1:0]        delta;
  logic signed [QUAT_W-1:0]  c;
  logic signed [QUAT_W-1:0]  s;
  logic [OPB_W-1:0]          c_mag;
  logic [OPB_W-1:0]          s_mag;
  logic                      p_neg;
  logic signed [95:0]        pfull;
  logic [POSITION_WIDTH-1:0] pstep;
  logic                      rej;

  logic [ANGLE_W-1:0]        heading;
  logic [POSITION_WIDTH-1:0] pos_x;
  logic [POSITION_WIDTH-1:0] pos_y;
  logic signed [SPEED_W-1:0] lin;
  logic signed [SPEED_W-1:0] ang;
  logic signed [QUAT_W-1:0]  qw;
  logic signed [QUAT_W-1:0]  qz;

  logic                        out_valid;
  logic                        out_rej;
  logic signed [SPEED_W-1:0]   out_lin;
  logic signed [SPEED_W-1:0]   out_ang;
  logic signed [POS_OUT_W-1:0] out_px;
  logic signed [POS_OUT_W-1:0] out_py;
  logic [ANGLE_W-1:0]          out_head;
  logic signed [QUAT_W-1:0]    out_qw;
  logic signed [QUAT_W-1:0]    out_qz;

  md_req_t            md_req;
  logic [OPA_W-1:0]   md_a;
  logic [OPB_W-1:0]   md_b;
  logic               md_done;
  logic [RES_W-1:0]   md_res;
  logic [DVS_W-1:0]   md_rem;
  logic               cor_start;
  logic [ANGLE_W-1:0] cor_angle;
  logic               cor_done;
  logic signed [QUAT_W-1:0] cor_cos;
  logic signed [QUAT_W-1:0] cor_sin;

  ddo_muldiv u_md (
    .clk  (clk),
    .rst  (rst),
    .req  (md_req),
    .a    (md_a),
    .b    (md_b),
    .done (md_done),
    .res  (md_res),
    .rem  (md_rem)
  );

  ddo_cordic #(.STEPS(CORDIC_STEPS)) u_cordic (
    .clk   (clk),
    .rst   (rst),
    .start (cor_start),
    .angle (cor_angle),
    .done  (cor_done),
    .cos_o (cor_cos),
    .sin_o (cor_sin)
  );

  assign cfg.ready    = 1'b1;
  assign sample.ready = (state == S_IDLE);

  assign pose.valid         = out_valid;
  assign pose.rejected      = out_rej;
  assign pose.linear_speed  = out_lin;
  assign pose.angular_speed = out_ang;
  assign pose.position_x    = out_px;
  assign pose.position_y    = out_py;
  assign pose.heading       = out_head;
  assign pose.quat_w        = out_qw;
  assign pose.quat_z        = out_qz;

  // zero divisors act as one
  assign pe = (per == '0) ? PER_W'(1) : per;
  assign we = (base == '0) ? BASE_W'(1) : base;
  assign pw = DVS_W'(pe) * DVS_W'(we);

  assign lmag_in = sample.left_count[COUNT_W-1] ? -{1'b1, sample.left_count}
                                                : {1'b0, sample.left_count};
  assign rmag_in = sample.right_count[COUNT_W-1] ? -{1'b1, sample.right_count}
                                                 : {1'b0, sample.right_count};
  assign rej_in  = (lmag_in >= {2'b0, thr}) || (rmag_in >= {2'b0, thr});

  assign cl_mag   = cl[COUNT_W-1] ? -cl : cl;
  assign cr_mag   = cr[COUNT_W-1] ? -cr : cr;
  assign sum_mag  = sum[41] ? -sum : sum;
  assign diff_mag = diff[41] ? -diff : diff;
  assign d_s      = (sum + signed'({41'b0, sum[41]})) >>> 1;
  assign d_mag    = d_s[41] ? -d_s : d_s;
  assign c_mag    = c[QUAT_W-1] ? -c : c;
  assign s_mag    = s[QUAT_W-1] ? -s : s;
  assign acc48    = qc + md_res[47:0];
  assign delta    = acc48[47:16];

  always_comb begin
    p_neg = d_s[41] ^ ((state == S_PY) ? s[QUAT_W-1] : c[QUAT_W-1]);
    pfull = signed'({12'b0, md_res});
    if (p_neg) begin
      pfull = -pfull;
    end
    pstep = pfull[30 +: POSITION_WIDTH];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      go    <= 1'b0;
    end else begin
      state <= state_next;
      go    <= (state_next != state);
    end
  end

  always_comb begin
    state_next = state;
    md_req     = '{start: 1'b0, op: OP_MUL};
    md_a       = '0;
    md_b       = '0;
    cor_start  = 1'b0;
    cor_angle  = heading;
    case (state)
      S_IDLE: begin
        if (sample.valid) state_next = rej_in ? S_OUT : S_DL;
      end
      S_DL: begin
        md_req = '{start: go, op: OP_MUL};
        md_a   = OPA_W'(cl_mag);
        md_b   = OPB_W'(mpp);
        if (md_done) state_next = S_DR;
      end
      S_DR: begin
        md_req = '{start: go, op: OP_MUL};
        md_a   = OPA_W'(cr_mag);
        md_b   = OPB_W'(mpp);
        if (md_done) state_next = S_SUMS;
      end
      S_SUMS: begin
        state_next = S_LIN;
      end
      S_LIN: begin
        md_req = '{start: go, op: OP_DIV};
        md_a   = OPA_W'(sum_mag);
        md_b   = OPB_W'({pe, 1'b0});
        if (md_done) state_next = S_AMUL;
      end
      S_AMUL: begin
        md_req = '{start: go, op: OP_MUL};
        md_a   = OPA_W'(diff_mag);
        md_b   = ANG_SCALE;
        if (md_done) state_next = S_ADIV;
      end
      S_ADIV: begin
        md_req = '{start: go, op: OP_DIV};
        md_a   = tmp;
        md_b   = OPB_W'(pw);
        if (md_done) state_next = S_QDIV;
      end
      S_QDIV: begin
        md_req = '{start: go, op: OP_DIV};
        md_a   = OPA_W'(diff_mag);
        md_b   = OPB_W'(we);
        if (md_done) state_next = S_QMUL;
      end
      S_QMUL: begin
        md_req = '{start: go, op: OP_MUL};
        md_a   = tmp;
        md_b   = TWO_PI_INV;
        if (md_done) state_next = S_RMUL;
      end
      S_RMUL: begin
        md_req = '{start: go, op: OP_MUL};
        md_a   = OPA_W'(rreg);
        md_b   = TWO_PI_INV;
        if (md_done) state_next = S_RDIV;
      end
      S_RDIV: begin
        md_req = '{start: go, op: OP_DIV};
        md_a   = tmp;
        md_b   = OPB_W'(we);
        if (md_done) state_next = S_COS1;
      end
      S_COS1: begin
        cor_start = go;
        if (cor_done) state_next = S_PX;
      end
      S_PX: begin
        md_req = '{start: go, op: OP_MUL};
        md_a   = OPA_W'(d_mag);
        md_b   = c_mag;
        if (md_done) state_next = S_PY;
      end
      S_PY: begin
        md_req = '{start: go, op: OP_MUL};
        md_a   = OPA_W'(d_mag);
        md_b   = s_mag;
        if (md_done) state_next = S_COS2;
      end
      S_COS2: begin
        cor_start = go;
        cor_angle = {1'b0, heading[ANGLE_W-1:1]};
        if (cor_done) state_next = S_OUT;
      end
      S_OUT: begin
        if (!out_valid || pose.ready) state_next = S_IDLE;
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      thr       <= THR_RESET;
      mpp       <= MPP_RESET;
      per       <= PER_RESET;
      base      <= BASE_RESET;
      heading   <= '0;
      pos_x     <= '0;
      pos_y     <= '0;
      lin       <= '0;
      ang       <= '0;
      qw        <= '0;
      qz        <= '0;
      out_valid <= 1'b0;
    end else begin
      if (cfg.valid) begin
        case (cfg.index)
          REG_THR:    thr  <= cfg.data[THR_W-1:0];
          REG_MPP:    mpp  <= cfg.data[MPP_W-1:0];
          REG_PERIOD: per  <= cfg.data[PER_W-1:0];
          REG_BASE:   base <= cfg.data[BASE_W-1:0];
          default: ;
        endcase
      end
      if (state == S_OUT && (!out_valid || pose.ready)) begin
        out_valid <= 1'b1;
      end else if (pose.ready) begin
        out_valid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (sample.valid) begin
            cl  <= sample.left_count;
            cr  <= sample.right_count;
            rej <= rej_in;
          end
        end
        S_DL: begin
          if (md_done) dl <= cl[COUNT_W-1] ? -signed'(md_res[40:0]) : signed'(md_res[40:0]);
        end
        S_DR: begin
          if (md_done) dr <= cr[COUNT_W-1] ? -signed'(md_res[40:0]) : signed'(md_res[40:0]);
        end
        S_SUMS: begin
          sum  <= {dl[40], dl} + {dr[40], dr};
          diff <= {dr[40], dr} - {dl[40], dl};
        end
        S_LIN: begin
          if (md_done) lin <= sat_signed(md_res[OPA_W-1:0], sum[41]);
        end
        S_AMUL: begin
          if (md_done) tmp <= md_res[OPA_W-1:0];
        end
        S_ADIV: begin
          if (md_done) ang <= sat_signed(md_res[OPA_W-1:0], diff[41]);
        end
        S_QDIV: begin
          if (md_done) begin
            tmp  <= md_res[OPA_W-1:0];
            rreg <= md_rem[BASE_W-1:0];
          end
        end
        S_QMUL: begin
          if (md_done) qc <= md_res[47:0];
        end
        S_RMUL: begin
          if (md_done) tmp <= md_res[OPA_W-1:0];
        end
        S_RDIV: begin
          if (md_done) heading <= diff[41] ? heading - delta : heading + delta;
        end
        S_COS1: begin
          if (cor_done) begin
            c <= cor_cos;
            s <= cor_sin;
          end
        end
        S_PX: begin
          if (md_done) pos_x <= pos_x + pstep;
        end
        S_PY: begin
          if (md_done) pos_y <= pos_y + pstep;
        end
        S_COS2: begin
          if (cor_done) begin
            qw <= cor_cos;
            qz <= cor_sin;
          end
        end
        S_OUT: begin
          if (!out_valid || pose.ready) begin
            out_rej   <= rej;
            out_lin   <= lin;
            out_ang   <= ang;
            out_px    <= POS_OUT_W'(pos_x);
            out_py    <= POS_OUT_W'(pos_y);
            out_head  <= heading;
            out_qw    <= qw;
            out_qz    <= qz;
          end
        end
        default: ;
      endcase
    end
  end

endmodule

>>> tb/sv/differential_drive_odometry_test.sv
// Self-checking bench for the wheel odometry block: directed table, then random
// wheel count requests under several idle/stall phases, checked against a local pose model.
// Depends on ddo_pkg, ddo_if and differential_drive_odometry.
module differential_drive_odometry_test;
  import ddo_pkg::*;

  localparam int STEPS = 24;
  localparam int WATCHDOG = 200000;

  logic clk = 1'b0;
  logic rst = 1'b1;
  always #10 clk = ~clk;

  ddo_in_if  sample();
  ddo_out_if pose();
  ddo_cfg_if cfg();

  differential_drive_odometry dut (.clk(clk), .rst(rst), .sample(sample), .pose(pose),
                                   .cfg(cfg));

  typedef struct {
    logic                 rejected;
    logic signed [31:0]   linear_speed;
    logic signed [31:0]   angular_speed;
    logic signed [47:0]   position_x;
    logic signed [47:0]   position_y;
    logic [31:0]          heading;
    logic signed [31:0]   quat_w;
    logic signed [31:0]   quat_z;
  } pose_t;

  typedef struct {
    logic signed [15:0] left;
    logic signed [15:0] right;
    logic               known;
    logic               rej;
  } row_t;

  // model configuration and state
  logic [14:0] m_thr;
  logic [23:0] m_mpp;
  logic [9:0]  m_per;
  logic [11:0] m_base;
  logic [31:0] m_heading;
  logic [47:0] m_px, m_py;
  logic signed [31:0] m_lin, m_ang, m_qw, m_qz;

  pose_t expected_poses[$];
  int errors = 0, results = 0, rejects = 0, sent = 0;
  int idle_pct = 0, stall_pct = 0;
  int quiet = 0;

  function automatic logic signed [31:0] clamp32(input logic signed [127:0] v);
    if (v > 128'sd2147483647) return 32'sh7FFF_FFFF;
    if (v < -128'sd2147483648) return 32'sh8000_0000;
    return v[31:0];
  endfunction

  function automatic longint floor_shift(input longint v, input int s);
    return v >>> s;
  endfunction

  function automatic longint atan_tab(input int i);
    longint t[32] = '{536870912, 316933406, 167458907, 85004756, 42667331, 21354465,
      10679838, 5340245, 2670163, 1335087, 667544, 333772, 166886, 83443, 41722, 20861,
      10430, 5215, 2608, 1304, 652, 326, 163, 81, 41, 20, 10, 5, 3, 1, 1, 0};
    return t[i];
  endfunction

  task automatic rotate(input logic [31:0] ang, output logic signed [31:0] cs,
                        output logic signed [31:0] sn);
    logic flip;
    longint x, y, z, t, dx, dy;
    logic [31:0] a;
    flip = ang[31] ^ ang[30];
    a = flip ? ang - 32'h8000_0000 : ang;
    x = 652032874;
    y = 0;
    z = longint'(signed'(a));
    for (int i = 0; i < STEPS; i++) begin
      dx = floor_shift(y, i);
      dy = floor_shift(x, i);
      if (z >= 0) begin
        t = x - dx; y = y + dy; x = t; z -= longint'(atan_tab(i));
      end else begin
        t = x + dx; y = y - dy; x = t; z += longint'(atan_tab(i));
      end
    end
    if (flip) begin
      x = -x; y = -y;
    end
    cs = clamp32(128'(x));
    sn = clamp32(128'(y));
  endtask

  function automatic logic [47:0] step_q30(input longint d, input logic signed [31:0] c);
    logic signed [127:0] p;
    p = 128'(d) * 128'(c);
    return 48'(p >>> 30);
  endfunction

  task automatic predict_pose(input logic signed [15:0] l, input logic signed [15:0] r,
                              output pose_t e);
    longint thr, p, w, dl, dr, sum, diff, d, mag, q, rm;
    logic [127:0] acc;
    logic [31:0] delta;
    logic signed [31:0] c, s;
    thr = m_thr;
    if (l <= -thr || l >= thr || r <= -thr || r >= thr) begin
      e.rejected = 1'b1;
    end else begin
      e.rejected = 1'b0;
      p = (m_per == 0) ? 1 : m_per;
      w = (m_base == 0) ? 1 : m_base;
      dl = longint'(l) * longint'(m_mpp);
      dr = longint'(r) * longint'(m_mpp);
      sum = dl + dr;
      diff = dr - dl;
      d = sum / 2;
      mag = diff < 0 ? -diff : diff;
      q = mag / w;
      rm = mag % w;
      acc = 128'(q) * 683565276 + (128'(rm) * 683565276) / 128'(w);
      delta = acc[47:16];
      m_lin = clamp32(128'(sum / (2 * p)));
      m_ang = clamp32(128'((diff * 1000) / (p * w)));
      if (diff < 0) delta = -delta;
      m_heading += delta;
      rotate(m_heading, c, s);
      m_px += step_q30(d, c);
      m_py += step_q30(d, s);
      rotate(m_heading >> 1, c, s);
      m_qw = c;
      m_qz = s;
    end
    e.linear_speed = m_lin;
    e.angular_speed = m_ang;
    e.position_x = m_px;
    e.position_y = m_py;
    e.heading = m_heading;
    e.quat_w = m_qw;
    e.quat_z = m_qz;
  endtask

  // request driver; valid stays up into the next request unless the sender idles
  task automatic send_counts(input logic signed [15:0] l, input logic signed [15:0] r);
    pose_t e;
    while (idle_pct > 0 && $urandom_range(99) < idle_pct) begin
      sample.valid <= 1'b0;
      @(posedge clk);
    end
    sample.valid <= 1'b1;
    sample.left_count <= l;
    sample.right_count <= r;
    @(posedge clk);
    while (!sample.ready) @(posedge clk);
    predict_pose(l, r, e);
    expected_poses.push_back(e);
    sent++;
  endtask

  task automatic write_reg(input cfg_reg_t idx, input logic [23:0] val);
    cfg.valid <= 1'b1;
    cfg.index <= idx;
    cfg.data <= val;
    @(posedge clk);
    while (!cfg.ready) @(posedge clk);
    case (idx)
      REG_THR:    m_thr = val[14:0];
      REG_MPP:    m_mpp = val;
      REG_PERIOD: m_per = val[9:0];
      REG_BASE:   m_base = val[11:0];
      default: ;
    endcase
  endtask

  task automatic drain;
    sample.valid <= 1'b0;
    while (expected_poses.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
  endtask

  task automatic set_regs(input logic [14:0] thr, input logic [23:0] mpp,
                          input logic [9:0] per, input logic [11:0] base);
    drain();
    write_reg(REG_THR, 24'(thr));
    write_reg(REG_MPP, mpp);
    write_reg(REG_PERIOD, 24'(per));
    write_reg(REG_BASE, 24'(base));
    cfg.valid <= 1'b0;
  endtask

  function automatic logic signed [15:0] rand_count(input int lim);
    if ($urandom_range(9) == 0) return 16'($urandom);
    return 16'($urandom_range(2 * lim) - lim);
  endfunction

  // result monitor
  always @(posedge clk) begin
    if (rst) begin
      pose.ready <= 1'b0;
    end else begin
      pose.ready <= !(stall_pct > 0 && $urandom_range(99) < stall_pct);
      if (sample.valid && sample.ready || pose.valid && pose.ready) quiet <= 0;
      else quiet <= quiet + 1;
      if (quiet > WATCHDOG) begin
        $display("watchdog: no request or result moved for %0d cycles", WATCHDOG);
        $display("Testbench completed WITH ERRORS");
        $finish;
      end
      if (pose.valid && pose.ready) begin
        results++;
        if (expected_poses.size() == 0) begin
          errors++;
          if (errors <= 10) $display("unexpected pose result");
        end else begin
          pose_t e;
          e = expected_poses.pop_front();
          if (e.rejected) rejects++;
          if (pose.rejected !== e.rejected || pose.linear_speed !== e.linear_speed ||
              pose.angular_speed !== e.angular_speed || pose.position_x !== e.position_x ||
              pose.position_y !== e.position_y || pose.heading !== e.heading ||
              pose.quat_w !== e.quat_w || pose.quat_z !== e.quat_z) begin
            errors++;
            if (errors <= 10) begin
              $display("pose mismatch #%0d: exp rej=%b lin=%0d ang=%0d x=%0d y=%0d",
                results, e.rejected, e.linear_speed, e.angular_speed, e.position_x,
                e.position_y);
              $display("  exp h=%h w=%0d z=%0d", e.heading, e.quat_w, e.quat_z);
              $display("  got rej=%b lin=%0d ang=%0d x=%0d y=%0d",
                pose.rejected, pose.linear_speed, pose.angular_speed, pose.position_x,
                pose.position_y);
              $display("  got h=%h w=%0d z=%0d", pose.heading, pose.quat_w, pose.quat_z);
            end
          end
        end
      end
    end
  end

  row_t directed[] = '{
    '{16'sd0, 16'sd0, 1'b0, 1'b0},
    '{16'sd519, 16'sd0, 1'b0, 1'b0},
    '{16'sd520, 16'sd0, 1'b1, 1'b1},
    '{16'sd0, -16'sd520, 1'b1, 1'b1},
    '{-16'sd519, 16'sd519, 1'b0, 1'b0},
    '{16'sd32767, -16'sd32768, 1'b1, 1'b1},
    '{16'sd100, 16'sd100, 1'b0, 1'b0},
    '{-16'sd100, -16'sd300, 1'b0, 1'b0},
    '{16'sd300, -16'sd300, 1'b0, 1'b0},
    '{-16'sd1, 16'sd1, 1'b0, 1'b0}
  };

  int phase_idle[4] = '{0, 78, 0, 18};
  int phase_stall[4] = '{0, 0, 78, 18};

  initial begin
    sample.valid = 1'b0;
    sample.left_count = '0;
    sample.right_count = '0;
    cfg.valid = 1'b0;
    cfg.index = REG_THR;
    cfg.data = '0;
    m_thr = THR_RESET; m_mpp = MPP_RESET; m_per = PER_RESET; m_base = BASE_RESET;
    m_heading = '0; m_px = '0; m_py = '0;
    m_lin = '0; m_ang = '0; m_qw = '0; m_qz = '0;
    repeat (2) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    foreach (directed[i]) begin
      send_counts(directed[i].left, directed[i].right);
      if (directed[i].known && expected_poses[$].rejected !== directed[i].rej) begin
        errors++;
        $display("directed row %0d: table and model disagree on reject", i);
      end
    end
    // register extremes: zero divisors, full scale travel, widest threshold
    set_regs(15'd32767, 24'hFF_FFFF, 10'd0, 12'd0);
    send_counts(16'sd32766, -16'sd32766);
    send_counts(-16'sd32766, -16'sd32766);
    set_regs(15'd1, 24'd1, 10'd1000, 12'd4095);
    send_counts(16'sd0, 16'sd0);
    send_counts(16'sd1, 16'sd0);
    set_regs(15'd0, 24'd9503, 10'd1, 12'd1);
    send_counts(16'sd0, 16'sd0);

    for (int ph = 0; ph < 4; ph++) begin
      drain();
      case (ph)
        0: set_regs(15'd520, 24'd9503, 10'd10, 12'd124);
        1: set_regs(15'($urandom_range(32767, 1)), 24'($urandom), 10'($urandom_range(1000, 1)),
                    12'($urandom_range(4095, 1)));
        2: set_regs(15'd32767, 24'd65536, 10'd1, 12'd1);
        default: set_regs(15'd2000, 24'($urandom_range(200000, 1)), 10'd7, 12'd300);
      endcase
      idle_pct = phase_idle[ph];
      stall_pct = phase_stall[ph];
      for (int n = 0; n < 235; n++) begin
        send_counts(rand_count(m_thr == 0 ? 1 : int'(m_thr)),
                    rand_count(m_thr == 0 ? 1 : int'(m_thr)));
      end
    end
    idle_pct = 0;
    stall_pct = 0;
    drain();
    $display("covered %0d requests, %0d results (%0d rejected) over four register settings",
             sent, results, rejects);
    if (errors == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end
endmodule

>>> files.f
design/ddo_pkg.sv
design/ddo_if.sv
design/ddo_muldiv.sv
design/ddo_cordic.sv
design/differential_drive_odometry.sv
tb/sv/differential_drive_odometry_test.sv
